@@ rtl/msera_pkg.sv @@
// ----------------------------------------------------------------------------
// msera_pkg: shared types and constants for the echo range averager
// Field widths, the range conversion factor, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package msera_pkg;

   // Fixed payload widths
   localparam int ECHO_W = 16;
   localparam int MM_W   = 14;
   localparam int IDX_W  = 3;
   localparam int MASK_W = 8;

   // 0.1716 mm/us in unsigned Q0.16, rounded
   localparam logic [MM_W-1:0] MM_PER_US_Q16 = 14'd11246;

   // Default geometry
   localparam int DEFAULT_SENSOR_SLOTS = 8;
   localparam int DEFAULT_RING_DEPTH   = 4;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } ctl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_in;  // capture request and selected slot
      logic read;     // read old ring sample, convert echo
      logic update;   // write ring, update sum, pick next slot
      logic divide;   // reciprocal multiply of the sum
      logic finish;   // correct quotient, load response
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;  // response register can take a new result
   } ctl_status_type;

endpackage

@@ rtl/msera_ctrl.sv @@
// ----------------------------------------------------------------------------
// msera_ctrl: sequencer for the echo range averager
// Walks one request through read, update, divide and finish steps.
// ----------------------------------------------------------------------------
module msera_ctrl
   import msera_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.divide = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            // hold here while the previous response is still pending
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/msera_dpath.sv @@
// ----------------------------------------------------------------------------
// msera_dpath: datapath for the echo range averager
// Echo conversion, per-slot sample rings with running sums, average by
// reciprocal multiply, next-slot search and the response register.
// ----------------------------------------------------------------------------
module msera_dpath
   import msera_pkg::*;
#(
   parameter int SENSOR_SLOTS = DEFAULT_SENSOR_SLOTS,
   parameter int RING_DEPTH   = DEFAULT_RING_DEPTH
)
(
   input  logic              clock,
   input  logic              reset,
   input  ctl_cmd_type       cmd,
   output ctl_status_type    status,
   input  logic              csr_wr_en,
   input  logic [MASK_W-1:0] csr_wr_data,
   input  logic [ECHO_W-1:0] req_echo_us,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [IDX_W-1:0]  rsp_sensor_index,
   output logic              rsp_stored,
   output logic [MM_W-1:0]   rsp_distance_mm,
   output logic [MM_W-1:0]   rsp_average_mm,
   output logic [IDX_W-1:0]  rsp_next_index
);

   localparam int SLOT_W  = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
   localparam int PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int ENTRIES = SENSOR_SLOTS * RING_DEPTH;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SUM_W   = MM_W + ((RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 0);
   localparam int PROD_W  = SUM_W + SUM_W + 1;
   localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'((1 << SUM_W) / RING_DEPTH);

   // Configuration and selection state
   logic [MASK_W-1:0] mask_ff;
   logic [SLOT_W-1:0] cur_slot_ff;
   logic [PTR_W-1:0]  ptr_ff [SENSOR_SLOTS];
   logic [SUM_W-1:0]  sum_ff [SENSOR_SLOTS];
   logic [ENTRIES-1:0] vld_ff;
   logic [MM_W-1:0]   mem [ENTRIES];

   // Per-request working registers
   logic [ECHO_W-1:0] echo_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [MM_W-1:0]   rd_data_ff;
   logic              rd_vld_ff;
   logic [MM_W-1:0]   mm_ff;
   logic [SUM_W-1:0]  sum_sel_ff;
   logic              stored_ff;
   logic [MM_W-1:0]   q0_ff;

   // Response register
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic              rsp_stored_ff;
   logic [MM_W-1:0]   rsp_dist_ff;
   logic [MM_W-1:0]   rsp_avg_ff;
   logic [IDX_W-1:0]  rsp_next_ff;

   logic [SENSOR_SLOTS-1:0]  en_vec;
   logic                     slot_en;
   logic [PTR_W-1:0]         cur_ptr;
   logic [PTR_W-1:0]         ptr_next;
   logic [ADDR_W-1:0]        rd_addr;
   logic [ECHO_W+MM_W-1:0]   mm_prod;
   logic [MM_W-1:0]          old_sample;
   logic [SUM_W-1:0]         sum_cur;
   logic [SUM_W-1:0]         sum_new;
   logic [SLOT_W-1:0]        next_slot;
   logic [PROD_W-1:0]        div_prod;
   logic [SUM_W-1:0]         q_times;
   logic [SUM_W-1:0]         rem;
   logic [MM_W-1:0]          avg;

   // Slot enables; slots past the mask width are never enabled
   for (genvar s = 0; s < SENSOR_SLOTS; s++) begin : g_en
      if (s < MASK_W) begin : g_on
         assign en_vec[s] = mask_ff[s];
      end else begin : g_off
         assign en_vec[s] = 1'b0;
      end
   end

   assign slot_en = en_vec[slot_ff];

   // Ring address and pointer advance
   assign cur_ptr  = ptr_ff[slot_ff];
   assign ptr_next = (cur_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : cur_ptr + PTR_W'(1);
   assign rd_addr  = ADDR_W'(int'(slot_ff) * RING_DEPTH + int'(cur_ptr));

   // Echo width to millimetres
   assign mm_prod = echo_ff * MM_PER_US_Q16;

   // Running sum update: never-written entries read as zero
   assign old_sample = rd_vld_ff ? rd_data_ff : '0;
   assign sum_cur    = sum_ff[slot_ff];
   assign sum_new    = sum_cur - SUM_W'(old_sample) + SUM_W'(mm_ff);

   // First enabled slot after the current one, wrapping; else stay
   always_comb begin
      int   cand;
      logic found;
      next_slot = slot_ff;
      found     = 1'b0;
      for (int i = 1; i < SENSOR_SLOTS; i++) begin
         cand = int'(slot_ff) + i;
         if (cand >= SENSOR_SLOTS) begin
            cand = cand - SENSOR_SLOTS;
         end
         if (!found && en_vec[SLOT_W'(cand)]) begin
            next_slot = SLOT_W'(cand);
            found     = 1'b1;
         end
      end
   end

   // Average: reciprocal estimate is exact or one low, fix with remainder
   assign div_prod = sum_sel_ff * RECIP;
   assign q_times  = SUM_W'(int'(q0_ff) * RING_DEPTH);
   assign rem      = sum_sel_ff - q_times;
   assign avg      = (rem >= SUM_W'(RING_DEPTH)) ? q0_ff + MM_W'(1) : q0_ff;

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         cur_slot_ff  <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SENSOR_SLOTS; s++) begin
            ptr_ff[s] <= '0;
            sum_ff[s] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            mask_ff <= csr_wr_data;
         end
         if (cmd.update) begin
            cur_slot_ff <= next_slot;
            if (slot_en) begin
               vld_ff[addr_ff]  <= 1'b1;
               ptr_ff[slot_ff]  <= ptr_next;
               sum_ff[slot_ff]  <= sum_new;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Sample memory
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (cmd.update && slot_en) begin
         mem[addr_ff] <= mm_ff;
      end
   end

   // Payload pipeline
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         echo_ff <= req_echo_us;
         slot_ff <= cur_slot_ff;
      end
      if (cmd.read) begin
         addr_ff   <= rd_addr;
         rd_vld_ff <= vld_ff[rd_addr];
         mm_ff     <= mm_prod[ECHO_W +: MM_W];
      end
      if (cmd.update) begin
         sum_sel_ff <= slot_en ? sum_new : sum_cur;
         stored_ff  <= slot_en;
      end
      if (cmd.divide) begin
         q0_ff <= div_prod[SUM_W +: MM_W];
      end
      if (cmd.finish) begin
         rsp_index_ff  <= IDX_W'(slot_ff);
         rsp_stored_ff <= stored_ff;
         rsp_dist_ff   <= mm_ff;
         rsp_avg_ff    <= avg;
         rsp_next_ff   <= IDX_W'(cur_slot_ff);
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sensor_index = rsp_index_ff;
   assign rsp_stored       = rsp_stored_ff;
   assign rsp_distance_mm  = rsp_dist_ff;
   assign rsp_average_mm   = rsp_avg_ff;
   assign rsp_next_index   = rsp_next_ff;

endmodule

@@ rtl/multi_sensor_echo_range_averager_top.sv @@
// ----------------------------------------------------------------------------
// multi_sensor_echo_range_averager_top: multi-sensor echo ranging averager
// Converts echo widths to distance and keeps a moving average per sensor.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one echo width in microseconds (0 = timeout) for the slot
//   currently selected. rsp_* returns one response per request: the slot,
//   whether the sample was stored, its distance in mm, the slot's ring
//   average after the update, and the slot to trigger next.
//   csr_wr_en/csr_wr_data write the 8-bit slot enable mask. The user must
//   write it only while idle; the block itself does not enforce this.
// Timing:
//   A request is taken in the idle cycle and steps through ring memory read,
//   ring/sum update, reciprocal multiply and quotient fix. The next request
//   is taken the cycle after the response loads, so requests never overlap.
// Reset:
//   Synchronous reset clears the mask, slot selection, ring pointers, running
//   sums and the per-entry valid bits, so all rings read as zero at once.
// Backpressure:
//   A pending response holds in its register; a new request is still taken
//   and processed, then waits in the last step until rsp_ready frees it.
// ----------------------------------------------------------------------------
module multi_sensor_echo_range_averager_top
   import msera_pkg::*;
#(
   parameter int SENSOR_SLOTS = DEFAULT_SENSOR_SLOTS,
   parameter int RING_DEPTH   = DEFAULT_RING_DEPTH
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [MASK_W-1:0] csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [ECHO_W-1:0] req_echo_us,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [IDX_W-1:0]  rsp_sensor_index,
   output logic              rsp_stored,
   output logic [MM_W-1:0]   rsp_distance_mm,
   output logic [MM_W-1:0]   rsp_average_mm,
   output logic [IDX_W-1:0]  rsp_next_index
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   // Sequencer
   msera_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath
   msera_dpath #(
      .SENSOR_SLOTS (SENSOR_SLOTS),
      .RING_DEPTH   (RING_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_echo_us      (req_echo_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sensor_index (rsp_sensor_index),
      .rsp_stored       (rsp_stored),
      .rsp_distance_mm  (rsp_distance_mm),
      .rsp_average_mm   (rsp_average_mm),
      .rsp_next_index   (rsp_next_index)
   );

endmodule

@@ sim/echo_range_checker.sv @@
// ----------------------------------------------------------------------------
// echo_range_checker: response checker for the echo range averager
// Watches the mask writes, requests and responses, predicts each response
// from its own copy of the slot rings, pointers and selection, and compares
// the responses field by field in order.
// ----------------------------------------------------------------------------
module echo_range_checker
   import msera_pkg::*;
#(
   parameter int SENSOR_SLOTS = DEFAULT_SENSOR_SLOTS,
   parameter int RING_DEPTH   = DEFAULT_RING_DEPTH
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [MASK_W-1:0] csr_wr_data,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [ECHO_W-1:0] req_echo_us,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [IDX_W-1:0]  rsp_sensor_index,
   input  logic              rsp_stored,
   input  logic [MM_W-1:0]   rsp_distance_mm,
   input  logic [MM_W-1:0]   rsp_average_mm,
   input  logic [IDX_W-1:0]  rsp_next_index,
   output int                mismatch_count,
   output int                open_requests
);

   typedef struct {
      logic [IDX_W-1:0] sensor_index;
      logic             stored;
      logic [MM_W-1:0]  distance_mm;
      logic [MM_W-1:0]  average_mm;
      logic [IDX_W-1:0] next_index;
   } range_result_type;

   // Responses still owed by the block, oldest first
   range_result_type pending_ranges[$];

   // Shadow of the block's state
   logic [MASK_W-1:0] slot_mask;
   logic [MM_W-1:0]   ring_mm [SENSOR_SLOTS][RING_DEPTH];
   int                ring_wr_ptr [SENSOR_SLOTS];
   int                sel_slot;
   int                rsp_seen;

   initial begin
      mismatch_count = 0;
      open_requests  = 0;
      rsp_seen       = 0;
   end

   function automatic bit slot_is_on(input int s);
      return (s < MASK_W) && (s < SENSOR_SLOTS) && slot_mask[s];
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: response %0d: %s", $time, rsp_seen, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   // One echo: convert, store into the selected slot's ring, average, advance
   task automatic predict_range(input logic [ECHO_W-1:0] echo, output range_result_type res);
      logic [31:0] product;
      int          slot;
      int          total;
      int          cand;
      int          k;
      bit          found;
      product         = 32'(echo) * 32'(MM_PER_US_Q16);
      res.distance_mm = product[16 +: MM_W];
      slot             = sel_slot % SENSOR_SLOTS;
      res.sensor_index = IDX_W'(slot);
      res.stored       = slot_is_on(slot);
      if (res.stored) begin
         ring_mm[slot][ring_wr_ptr[slot]] = res.distance_mm;
         ring_wr_ptr[slot] = (ring_wr_ptr[slot] + 1) % RING_DEPTH;
      end
      total = 0;
      for (k = 0; k < RING_DEPTH; k++)
         total += ring_mm[slot][k];
      res.average_mm = MM_W'(total / RING_DEPTH);
      // first enabled slot after the current one, wrapping; else stay
      found = 0;
      for (k = 1; k < SENSOR_SLOTS; k++) begin
         cand = (slot + k) % SENSOR_SLOTS;
         if (!found && slot_is_on(cand)) begin
            found = 1;
            slot  = cand;
         end
      end
      sel_slot       = slot;
      res.next_index = IDX_W'(slot);
   endtask

   always @(posedge clock) begin : monitor
      range_result_type want;
      range_result_type fresh;
      int s;
      int k;
      if (reset) begin
         slot_mask = '0;
         sel_slot  = 0;
         for (s = 0; s < SENSOR_SLOTS; s++) begin
            ring_wr_ptr[s] = 0;
            for (k = 0; k < RING_DEPTH; k++)
               ring_mm[s][k] = '0;
         end
         pending_ranges.delete();
      end else begin
         // response side
         if (rsp_valid && rsp_ready) begin
            if (pending_ranges.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = pending_ranges.pop_front();
               check_field("sensor_index", rsp_sensor_index, want.sensor_index);
               check_field("stored", rsp_stored, want.stored);
               check_field("distance_mm", rsp_distance_mm, want.distance_mm);
               check_field("average_mm", rsp_average_mm, want.average_mm);
               check_field("next_index", rsp_next_index, want.next_index);
            end
            rsp_seen++;
         end
         // mask write
         if (csr_wr_en)
            slot_mask = csr_wr_data;
         // request side
         if (req_valid && req_ready) begin
            predict_range(req_echo_us, fresh);
            pending_ranges.push_back(fresh);
         end
      end
      open_requests = pending_ranges.size();
   end

endmodule

@@ sim/multi_sensor_echo_range_averager_top_tb.sv @@
// ----------------------------------------------------------------------------
// multi_sensor_echo_range_averager_top_tb: testbench for the echo averager
// Drives echo widths through a directed sequence and random mask phases with
// random idling on both channels; the checker predicts and compares every
// response, and this top gives the verdict.
// ----------------------------------------------------------------------------
module multi_sensor_echo_range_averager_top_tb;
   import msera_pkg::*;

   localparam int SENSOR_SLOTS    = DEFAULT_SENSOR_SLOTS;
   localparam int RING_DEPTH      = DEFAULT_RING_DEPTH;
   localparam int RANDOM_REQUESTS = 700;
   localparam int STALL_LIMIT     = 2000;
   localparam int IDLE_PERCENT    = 37;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [MASK_W-1:0] csr_wr_data;
   logic              req_valid;
   logic              req_ready;
   logic [ECHO_W-1:0] req_echo_us;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [IDX_W-1:0]  rsp_sensor_index;
   logic              rsp_stored;
   logic [MM_W-1:0]   rsp_distance_mm;
   logic [MM_W-1:0]   rsp_average_mm;
   logic [IDX_W-1:0]  rsp_next_index;

   int mismatch_count;
   int open_requests;
   int requests_sent;
   int directed_sent;
   int responses_taken;
   int mask_writes;
   int stall_cycles;
   bit no_idle;

   multi_sensor_echo_range_averager_top #(
      .SENSOR_SLOTS (SENSOR_SLOTS),
      .RING_DEPTH   (RING_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_echo_us      (req_echo_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sensor_index (rsp_sensor_index),
      .rsp_stored       (rsp_stored),
      .rsp_distance_mm  (rsp_distance_mm),
      .rsp_average_mm   (rsp_average_mm),
      .rsp_next_index   (rsp_next_index)
   );

   echo_range_checker #(
      .SENSOR_SLOTS (SENSOR_SLOTS),
      .RING_DEPTH   (RING_DEPTH)
   ) range_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_echo_us      (req_echo_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sensor_index (rsp_sensor_index),
      .rsp_stored       (rsp_stored),
      .rsp_distance_mm  (rsp_distance_mm),
      .rsp_average_mm   (rsp_average_mm),
      .rsp_next_index   (rsp_next_index),
      .mismatch_count   (mismatch_count),
      .open_requests    (open_requests)
   );

   // 2-unit clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Response backpressure, drawn fresh each falling edge
   always @(negedge clock) begin
      rsp_ready = no_idle || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         responses_taken++;
   end

   // Watchdog: too long without any request or response moving
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // One request: optional random gap, then hold valid until taken
   task automatic send_echo(input logic [ECHO_W-1:0] us);
      @(negedge clock);
      while (!no_idle && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_echo_us = us;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      requests_sent++;
   endtask

   // Hold off new requests until every response is back
   task automatic drain_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (open_requests != 0)
         @(negedge clock);
   endtask

   task automatic write_mask(input logic [MASK_W-1:0] mask);
      drain_responses();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = mask;
      @(negedge clock);
      csr_wr_en = 1'b0;
      mask_writes++;
   endtask

   // Mostly in-range widths, with timeouts, the top of range and full 16 bits
   function automatic logic [ECHO_W-1:0] pick_echo();
      case ($urandom_range(9))
         0:       return '0;
         1:       return ECHO_W'(50000);
         2:       return ECHO_W'($urandom);
         3:       return '1;
         default: return ECHO_W'($urandom_range(50000));
      endcase
   endfunction

   initial begin
      int phase;
      int count;
      int n;
      logic [MASK_W-1:0] mask;
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_valid       = 1'b0;
      req_echo_us     = '0;
      rsp_ready       = 1'b0;
      no_idle         = 1'b0;
      requests_sent   = 0;
      responses_taken = 0;
      mask_writes     = 0;
      stall_cycles    = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // mask still zero after reset: slot 0 disabled, selection stays
      send_echo(16'd1234);
      // all slots on: timeout, extremes and bit patterns across slots 0..7
      write_mask(8'hFF);
      send_echo(16'd0);
      send_echo(16'hFFFF);
      send_echo(16'd50000);
      send_echo(16'd1);
      send_echo(16'd6);
      send_echo(16'd382);
      send_echo(16'h8000);
      send_echo(16'h7FFF);
      // only the top slot: disabled slot 0 hands over, then slot 7 stays
      write_mask(8'h80);
      send_echo(16'd100);
      send_echo(16'd200);
      send_echo(16'd300);
      // slot 7 switched off under the selector: unchanged average, wrap to 0
      write_mask(8'h01);
      send_echo(16'd400);
      send_echo(16'd500);
      // sparse mask
      write_mask(8'h55);
      send_echo(16'd600);
      send_echo(16'd700);
      send_echo(16'd800);
      send_echo(16'd900);
      directed_sent = requests_sent;

      // random phases, each with its own mask
      phase = 0;
      count = 0;
      while (count < RANDOM_REQUESTS) begin
         case (phase)
            0:       mask = 8'hFF;
            1:       mask = 8'h00;
            2:       mask = MASK_W'(1) << $urandom_range(MASK_W - 1);
            default: mask = MASK_W'($urandom);
         endcase
         write_mask(mask);
         no_idle = (phase == 3);
         n = $urandom_range(20, 60);
         repeat (n) begin
            send_echo(pick_echo());
            count++;
            if ($urandom_range(49) == 0)
               drain_responses();
         end
         phase++;
      end
      no_idle = 1'b0;

      drain_responses();
      repeat (10) @(posedge clock);
      $display("Run: %0d requests (%0d directed), %0d responses, %0d mask writes",
               requests_sent, directed_sent, responses_taken, mask_writes);
      $display("Covered disabled and lone slots, timeouts, full-range widths, idle gaps");
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
